[design/olad_pkg.sv]
// Shared types and constants for the ordered list block.
// No dependencies; imported by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package olad_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int DATA_W           = 32;
  localparam int STATUS_W         = 3;
  localparam int ECOUNT_W         = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic              cmp;
    logic              del;
    logic              ins;
    logic [DATA_W-1:0] key;
  } cell_ctl_t;

endpackage

[design/olad_req_if.sv]
// Request channel: command and value with valid/ready handshake.
// Depends on olad_pkg.
`timescale 1ns / 1ps

interface olad_req_if
  import olad_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

[design/olad_rsp_if.sv]
// Result channel: status and entry count with valid/ready handshake.
// Depends on olad_pkg.
`timescale 1ns / 1ps

interface olad_rsp_if
  import olad_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ECOUNT_W-1:0] entry_count;

  modport source (output valid, status, entry_count, input ready);
  modport sink   (input valid, status, entry_count, output ready);
endinterface

[design/olad_cell.sv]
// One list cell: holds one entry, compares it with the key and passes
// the first-match flag and its entry to its neighbors. Depends on olad_pkg.
`timescale 1ns / 1ps

module olad_cell
  import olad_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT,
  parameter int INDEX    = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cell_ctl_t                           ctl,
  input  logic [$clog2(CAPACITY+1)-1:0]       count,
  input  logic [DATA_W-1:0]                   next_entry,
  input  logic                                match_in,
  output logic                                match_out,
  output logic [DATA_W-1:0]                   entry
);
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam logic [COUNT_W-1:0] IDX = COUNT_W'(INDEX);

  logic in_use;
  logic tail;
  logic hit;
  logic seen;

  assign in_use    = IDX < count;
  assign tail      = IDX == count;
  assign seen      = match_in | hit;
  assign match_out = seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.cmp) begin
      hit <= in_use && (entry == ctl.key);
    end
  end

  // close up behind the first match, or take the appended value at the tail
  always_ff @(posedge clk) begin
    if (ctl.del && seen) begin
      entry <= next_entry;
    end else if (ctl.ins && tail) begin
      entry <= ctl.key;
    end
  end
endmodule

[design/ordered_list_append_delete_top.sv]
// Top level of the ordered list: control sequencer, result register and
// the row of olad_cell instances. Depends on olad_pkg, olad_req_if,
// olad_rsp_if and olad_cell.
//
// Usage:
//   req carries one request (command, value); rsp returns one result
//   (status, entry_count) for every request, in order.
//   In the accept cycle every cell compares its entry with the key at
//   once; in the update step (S_APPLY), which holds while the output
//   register holds a result not yet taken, the first-match flag ripples
//   down the cell row and the cells shift or load. One request is in work
//   at a time: a new request is accepted only once the last one's update
//   step is done. rsp.valid is registered at the end of the update step.
//   A result waits in the output register while rsp.ready is low; the
//   next request is still accepted, and its update step holds until the
//   output register is free.
//   Reset (rst, synchronous) empties the list and drops any pending result;
//   entry contents are not cleared and are never read before written.
`timescale 1ns / 1ps

module ordered_list_append_delete_top
  import olad_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  olad_req_if.sink   req,
  olad_rsp_if.source rsp
);
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAPACITY);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_APPLY = 1'b1;

  logic                state;
  logic                cmd;
  logic [DATA_W-1:0]   key;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_next;
  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [ECOUNT_W-1:0] rsp_count;
  logic [STATUS_W-1:0] status_next;

  logic                accept;
  logic                apply_fire;
  logic                full;
  logic                found;
  cell_ctl_t           ctl;

  logic [DATA_W-1:0]   entry [CAPACITY];
  logic                match [CAPACITY+1];

  assign req.ready       = state == S_IDLE;
  assign accept          = req.valid && req.ready;
  assign apply_fire      = (state == S_APPLY) && (!rsp_valid || rsp.ready);
  assign full            = count == CAP;
  assign found           = match[CAPACITY];
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.entry_count = rsp_count;

  always_comb begin
    ctl.cmp = accept;
    ctl.del = apply_fire && (cmd == CMD_DELETE) && found;
    ctl.ins = apply_fire && (cmd == CMD_INSERT) && !full;
    ctl.key = accept ? req.value : key;
  end

  always_comb begin
    count_next  = count;
    status_next = ST_INSERTED;
    if (cmd == CMD_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_INSERTED;
        count_next  = count + 1'b1;
      end
    end else if (count == '0) begin
      status_next = ST_EMPTY;
    end else if (found) begin
      status_next = ST_DELETED;
      count_next  = count - 1'b1;
    end else begin
      status_next = ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (apply_fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (apply_fire) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= req.command;
      key <= req.value;
    end
    if (apply_fire) begin
      rsp_status <= status_next;
      rsp_count  <= ECOUNT_W'(count_next);
    end
  end

  assign match[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] nxt;
    if (i < CAPACITY - 1) begin : g_mid
      assign nxt = entry[i+1];
    end else begin : g_last
      assign nxt = entry[i];
    end
    olad_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .count      (count),
      .next_entry (nxt),
      .match_in   (match[i]),
      .match_out  (match[i+1]),
      .entry      (entry[i])
    );
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("entry count above capacity");

  a_apply_result : assert property (@(posedge clk) disable iff (rst)
    apply_fire |=> rsp_valid)
    else $error("update step without result");

  a_insert_grow : assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> count == $past(count) + 1'b1)
    else $error("append did not grow the list");

  a_delete_shrink : assert property (@(posedge clk) disable iff (rst)
    ctl.del |=> (count == $past(count) - 1'b1) && (rsp_status == ST_DELETED))
    else $error("delete did not shrink the list");

endmodule

[tb/sv/ordered_list_append_delete_top_tb.sv]
// Testbench for ordered_list_append_delete_top: directed and random append/delete
// requests, with a list scoreboard that predicts status and entry count per request.
// Depends on olad_pkg, olad_req_if, olad_rsp_if and the top level.
`timescale 1ns / 1ps

module ordered_list_append_delete_top_tb
  import olad_pkg::*;
();

  localparam int LIST_CAP   = CAPACITY_DEFAULT;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_ITEMS = 1950;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ECOUNT_W-1:0] entry_count;
  } list_result_t;

  class list_scoreboard;
    logic signed [DATA_W-1:0] held[$];
    list_result_t             due[$];
    int                       capacity;
    int                       errors;

    function new(int cap);
      capacity = cap;
      errors   = 0;
    endfunction

    function void note_request(logic cmd, logic signed [DATA_W-1:0] key);
      list_result_t r;
      int           hit;
      hit = -1;
      if (cmd == CMD_INSERT) begin
        if (held.size() >= capacity) begin
          r.status = ST_FULL;
        end else begin
          held.push_back(key);
          r.status = ST_INSERTED;
        end
      end else if (held.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        for (int i = 0; i < held.size(); i++) begin
          if (hit < 0 && held[i] == key) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          held.delete(hit);
          r.status = ST_DELETED;
        end
      end
      r.entry_count = ECOUNT_W'(held.size());
      due.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 50) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [STATUS_W-1:0] st, logic [ECOUNT_W-1:0] cnt);
      list_result_t want;
      if (due.size() == 0) begin
        report($sformatf("unexpected result status %0d count %0d", st, cnt));
        return;
      end
      want = due.pop_front();
      if (st !== want.status)
        report($sformatf("status %0d, want %0d", st, want.status));
      if (cnt !== want.entry_count)
        report($sformatf("entry_count %0d, want %0d", cnt, want.entry_count));
    endtask
  endclass

  logic clk;
  logic rst;
  int   send_pct;
  int   recv_pct;
  int   idle_cycles;

  logic signed [DATA_W-1:0] key_pool [8] = '{
    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF,
    32'sh0000_0001, 32'sh5A5A_5A5A, 32'shA5A5_A5A5, 32'sh0000_0007
  };

  list_scoreboard sb;

  olad_req_if req_ch ();
  olad_rsp_if rsp_ch ();

  ordered_list_append_delete_top #(
    .CAPACITY(LIST_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_result(rsp_ch.status, rsp_ch.entry_count);
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("ordered_list_append_delete_top_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(logic cmd, logic signed [DATA_W-1:0] key);
    while ($urandom_range(99) < send_pct) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid   <= 1'b1;
    req_ch.command <= cmd;
    req_ch.value   <= key;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(cmd, key);
  endtask

  task automatic random_request(int ins_pct);
    logic                     cmd;
    logic signed [DATA_W-1:0] key;
    cmd = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_DELETE;
    if ($urandom_range(9) < 3) key = $urandom;
    else key = key_pool[$urandom_range(7)];
    if (cmd == CMD_DELETE && sb.held.size() > 0 && $urandom_range(99) < 60)
      key = sb.held[$urandom_range(sb.held.size() - 1)];
    send_request(cmd, key);
  endtask

  initial begin
    int ins_bias [3] = '{85, 20, 55};
    sb             = new(LIST_CAP);
    send_pct       = 0;
    recv_pct       = 0;
    idle_cycles    = 0;
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.command = CMD_INSERT;
    req_ch.value   = '0;
    rsp_ch.ready   = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty list, extremes, duplicates, miss, fill to full, refused append
    send_request(CMD_DELETE, VAL_MIN);
    send_request(CMD_INSERT, VAL_MIN);
    send_request(CMD_INSERT, VAL_MAX);
    send_request(CMD_INSERT, 32'sh0000_0000);
    send_request(CMD_INSERT, 32'shFFFF_FFFF);
    send_request(CMD_INSERT, VAL_MAX);
    send_request(CMD_DELETE, 32'sh0000_0005);
    send_request(CMD_DELETE, VAL_MAX);
    send_request(CMD_DELETE, VAL_MIN);
    for (int k = 0; k < LIST_CAP - 3; k++)
      send_request(CMD_INSERT, DATA_W'(32'h1111_1111 * (k + 1)));
    send_request(CMD_INSERT, VAL_MIN);
    send_request(CMD_DELETE, 32'shFFFF_FFFF);
    send_request(CMD_DELETE, VAL_MAX);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      case (i / (RAND_ITEMS / 4))
        0:       begin send_pct = 0;  recv_pct = 0;  end
        1:       begin send_pct = 53; recv_pct = 0;  end
        2:       begin send_pct = 0;  recv_pct = 53; end
        default: begin send_pct = 26; recv_pct = 26; end
      endcase
      random_request(ins_bias[(i / 40) % 3]);
    end
    @(negedge clk);
    req_ch.valid <= 1'b0;

    while (sb.due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ordered_list_append_delete_top_tb: PASS");
    end else begin
      $display("ordered_list_append_delete_top_tb: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
design/olad_pkg.sv
design/olad_req_if.sv
design/olad_rsp_if.sv
design/olad_cell.sv
design/ordered_list_append_delete_top.sv
tb/sv/ordered_list_append_delete_top_tb.sv
